/* rtl/uartrf_pkg.sv */
// ----------------------------------------------------------------------------
// UART register file package
// Shared types, register offsets and status codes of the UART register file.
// ----------------------------------------------------------------------------
package uartrf_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_RX    = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_RSVD = 2'd3
  } access_size_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY_RBR = 3'd1,
    ST_IER_UPPER = 3'd2,
    ST_FIFO      = 3'd3,
    ST_UNMAPPED  = 3'd4
  } status_e;

  // Register offsets.
  localparam logic [15:0] ADDR_RBR_THR = 16'h0000;
  localparam logic [15:0] ADDR_IER     = 16'h0004;
  localparam logic [15:0] ADDR_IIR_FCR = 16'h0008;
  localparam logic [15:0] ADDR_LCR     = 16'h000C;
  localparam logic [15:0] ADDR_MCR     = 16'h0010;
  localparam logic [15:0] ADDR_LSR     = 16'h0014;

  localparam int unsigned DLAB_BIT     = 7;
  localparam logic [7:0]  LSR_BASE     = 8'h60;
  localparam logic [7:0]  IER_BAD_BITS = 8'hF0;
  localparam logic [7:0]  FCR_OK_BITS  = 8'h06;

  // Interrupt identification values.
  localparam logic [7:0]  IIR_RX       = 8'd4;
  localparam logic [7:0]  IIR_TX       = 8'd2;
  localparam logic [7:0]  IIR_NONE     = 8'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] reg_addr;
    logic [1:0]  access_size;
    logic [7:0]  write_data;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
    logic [2:0] status;
  } rsp_t;

endpackage

/* rtl/uartrf_if.sv */
// ----------------------------------------------------------------------------
// UART register file channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface uartrf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] reg_addr;
  logic [1:0]  access_size;
  logic [7:0]  write_data;
  logic [7:0]  rx_byte;

  modport source (output valid, req_type, reg_addr, access_size, write_data, rx_byte,
                  input ready);
  modport sink   (input valid, req_type, reg_addr, access_size, write_data, rx_byte,
                  output ready);
endinterface

interface uartrf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       irq;
  logic [2:0] status;

  modport source (output valid, read_data, tx_valid, tx_byte, irq, status,
                  input ready);
  modport sink   (input valid, read_data, tx_valid, tx_byte, irq, status,
                  output ready);
endinterface

/* rtl/uart_register_file_top.sv */
// ----------------------------------------------------------------------------
// UART register file
// 16550-style register model: bus reads, bus writes and line bytes in, one
// result per transaction out.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Handshake     | Payload
//   --------+-----+---------------+--------------------------------------------
//   req_i   | in  | valid/ready   | req_type, reg_addr, access_size,
//           |     |               | write_data, rx_byte
//   rsp_o   | out | valid/ready   | read_data, tx_valid, tx_byte, irq, status
//
// A request is captured in an input register and resolved when it moves into
// the result register, which it cannot do while that register holds a stalled
// result. One transaction per cycle is sustained while rsp_o is ready.
// The input register refills in the same cycle it drains, so a stalled result
// holds back at most the one request behind it.
// Reset clears all UART registers and both stage valid bits.
//
module uart_register_file_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  uartrf_req_if.sink          req_i,
  uartrf_rsp_if.source        rsp_o
);

  logic               in_vld_q;
  uartrf_pkg::req_t   in_q;
  logic               out_vld_q;
  uartrf_pkg::rsp_t   out_q;
  uartrf_pkg::rsp_t   core_rsp;
  logic               move;

  assign move        = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= '{req_type:    req_i.req_type,
                reg_addr:    req_i.reg_addr,
                access_size: req_i.access_size,
                write_data:  req_i.write_data,
                rx_byte:     req_i.rx_byte};
    end
  end

  uartrf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (move),
    .req_i  (in_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= core_rsp;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.read_data = out_q.read_data;
  assign rsp_o.tx_valid  = out_q.tx_valid;
  assign rsp_o.tx_byte   = out_q.tx_byte;
  assign rsp_o.irq       = out_q.irq;
  assign rsp_o.status    = out_q.status;

  // A transmitted byte always comes from a clean THR write and raises the interrupt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.tx_valid |-> out_q.status == uartrf_pkg::ST_OK && out_q.irq)
    else $error("transmit result with bad status or no interrupt");

  // Unmapped accesses return no data and send nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status == uartrf_pkg::ST_UNMAPPED |->
      out_q.read_data == '0 && !out_q.tx_valid)
    else $error("unmapped access produced data");

  // A received line byte always leaves the interrupt asserted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && in_q.req_type == uartrf_pkg::REQ_RX |=> out_vld_q && out_q.irq)
    else $error("line byte did not raise the interrupt");

  // The result valid bit only rises through a move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q && !move |=> !out_vld_q)
    else $error("result appeared without a transaction");

endmodule

/* rtl/uartrf_core.sv */
// ----------------------------------------------------------------------------
// UART register file core
// Register state and the decode that turns one transaction into its result.
// ----------------------------------------------------------------------------
module uartrf_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  uartrf_pkg::req_t   req_i,
  output uartrf_pkg::rsp_t   rsp_o
);

  logic [7:0] rx_data_q, rx_data_d;
  logic       rx_full_q, rx_full_d;
  logic       tx_pend_q, tx_pend_d;
  logic [7:0] dll_q, dll_d;
  logic [7:0] dlm_q, dlm_d;
  logic [7:0] ier_q, ier_d;
  logic [7:0] lcr_q, lcr_d;

  logic       dlab;
  logic [7:0] rd;
  logic       txv;
  logic [7:0] txb;
  uartrf_pkg::status_e st;

  assign dlab = lcr_q[uartrf_pkg::DLAB_BIT];

  always_comb begin
    rx_data_d = rx_data_q;
    rx_full_d = rx_full_q;
    tx_pend_d = tx_pend_q;
    dll_d     = dll_q;
    dlm_d     = dlm_q;
    ier_d     = ier_q;
    lcr_d     = lcr_q;
    rd        = '0;
    txv       = 1'b0;
    txb       = '0;
    st        = uartrf_pkg::ST_OK;

    unique case (uartrf_pkg::req_type_e'(req_i.req_type))
      uartrf_pkg::REQ_READ: begin
        if (req_i.access_size == uartrf_pkg::SIZE_BYTE ||
            req_i.access_size == uartrf_pkg::SIZE_WORD) begin
          unique case (req_i.reg_addr)
            uartrf_pkg::ADDR_RBR_THR: begin
              if (dlab) begin
                rd = dll_q;
              end else begin
                rd        = rx_data_q;
                rx_full_d = 1'b0;
                st        = rx_full_q ? uartrf_pkg::ST_OK : uartrf_pkg::ST_EMPTY_RBR;
              end
            end
            uartrf_pkg::ADDR_IER: begin
              rd = dlab ? dlm_q : ier_q;
            end
            uartrf_pkg::ADDR_IIR_FCR: begin
              if (rx_full_q) begin
                rd = uartrf_pkg::IIR_RX;
              end else if (tx_pend_q) begin
                rd        = uartrf_pkg::IIR_TX;
                tx_pend_d = 1'b0;
              end else begin
                rd = uartrf_pkg::IIR_NONE;
              end
            end
            uartrf_pkg::ADDR_LCR: begin
              rd = lcr_q;
            end
            uartrf_pkg::ADDR_LSR: begin
              rd = uartrf_pkg::LSR_BASE | {7'd0, rx_full_q};
            end
            default: begin
              st = uartrf_pkg::ST_UNMAPPED;
            end
          endcase
        end else begin
          st = uartrf_pkg::ST_UNMAPPED;
        end
      end
      uartrf_pkg::REQ_WRITE: begin
        if (req_i.access_size == uartrf_pkg::SIZE_BYTE) begin
          unique case (req_i.reg_addr)
            uartrf_pkg::ADDR_RBR_THR: begin
              if (dlab) begin
                dll_d = req_i.write_data;
              end else begin
                txv       = 1'b1;
                txb       = req_i.write_data;
                tx_pend_d = 1'b1;
              end
            end
            uartrf_pkg::ADDR_IER: begin
              if (dlab) begin
                dlm_d = req_i.write_data;
              end else begin
                ier_d = req_i.write_data;
                if ((req_i.write_data & uartrf_pkg::IER_BAD_BITS) != '0) begin
                  st = uartrf_pkg::ST_IER_UPPER;
                end
              end
            end
            uartrf_pkg::ADDR_IIR_FCR: begin
              // Only the FIFO reset bits are tolerated; anything else asks for FIFOs.
              if ((req_i.write_data & ~uartrf_pkg::FCR_OK_BITS) != '0) begin
                st = uartrf_pkg::ST_FIFO;
              end
            end
            uartrf_pkg::ADDR_LCR: begin
              lcr_d = req_i.write_data;
            end
            uartrf_pkg::ADDR_MCR: begin
              st = uartrf_pkg::ST_OK;
            end
            default: begin
              st = uartrf_pkg::ST_UNMAPPED;
            end
          endcase
        end else begin
          st = uartrf_pkg::ST_UNMAPPED;
        end
      end
      uartrf_pkg::REQ_RX: begin
        rx_data_d = req_i.rx_byte;
        rx_full_d = 1'b1;
      end
      default: begin
        st = uartrf_pkg::ST_UNMAPPED;
      end
    endcase
  end

  assign rsp_o.read_data = rd;
  assign rsp_o.tx_valid  = txv;
  assign rsp_o.tx_byte   = txb;
  assign rsp_o.irq       = rx_full_d | tx_pend_d;
  assign rsp_o.status    = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_data_q <= '0;
      rx_full_q <= 1'b0;
      tx_pend_q <= 1'b0;
      dll_q     <= '0;
      dlm_q     <= '0;
      ier_q     <= '0;
      lcr_q     <= '0;
    end else if (en_i) begin
      rx_data_q <= rx_data_d;
      rx_full_q <= rx_full_d;
      tx_pend_q <= tx_pend_d;
      dll_q     <= dll_d;
      dlm_q     <= dlm_d;
      ier_q     <= ier_d;
      lcr_q     <= lcr_d;
    end
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// UART register file testbench
// Drives bus reads, bus writes and line bytes into the register file with
// random gaps and result stalls. A scoreboard tracks the register state,
// predicts each result and compares every field in order of acceptance.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1450;

  class uart_scoreboard;
    uartrf_pkg::rsp_t expected_rsp_q[$];
    logic [7:0] rx_data;
    logic       rx_full;
    logic       tx_pending;
    logic [7:0] divisor_low;
    logic [7:0] divisor_high;
    logic [7:0] int_enable;
    logic [7:0] line_control;
    int         errors;
    int         checked;
    int         tx_count;
    int         kind_count[4];
    int         status_count[5];

    function new();
      rx_data      = '0;
      rx_full      = 1'b0;
      tx_pending   = 1'b0;
      divisor_low  = '0;
      divisor_high = '0;
      int_enable   = '0;
      line_control = '0;
    endfunction

    // Applies one request to the register state and returns its result.
    function uartrf_pkg::rsp_t resolve_request(uartrf_pkg::req_t r);
      uartrf_pkg::rsp_t o;
      logic dlab;
      o        = '0;
      o.status = uartrf_pkg::ST_OK;
      dlab     = line_control[uartrf_pkg::DLAB_BIT];
      case (r.req_type)
        uartrf_pkg::REQ_READ: begin
          if (r.access_size == uartrf_pkg::SIZE_BYTE ||
              r.access_size == uartrf_pkg::SIZE_WORD) begin
            case (r.reg_addr)
              uartrf_pkg::ADDR_RBR_THR: begin
                if (dlab) begin
                  o.read_data = divisor_low;
                end else begin
                  if (!rx_full) o.status = uartrf_pkg::ST_EMPTY_RBR;
                  rx_full     = 1'b0;
                  o.read_data = rx_data;
                end
              end
              uartrf_pkg::ADDR_IER: o.read_data = dlab ? divisor_high : int_enable;
              uartrf_pkg::ADDR_IIR_FCR: begin
                if (rx_full) begin
                  o.read_data = uartrf_pkg::IIR_RX;
                end else if (tx_pending) begin
                  tx_pending  = 1'b0;
                  o.read_data = uartrf_pkg::IIR_TX;
                end else begin
                  o.read_data = uartrf_pkg::IIR_NONE;
                end
              end
              uartrf_pkg::ADDR_LCR: o.read_data = line_control;
              uartrf_pkg::ADDR_LSR: o.read_data = uartrf_pkg::LSR_BASE | {7'd0, rx_full};
              default:  o.status = uartrf_pkg::ST_UNMAPPED;
            endcase
          end else begin
            o.status = uartrf_pkg::ST_UNMAPPED;
          end
        end
        uartrf_pkg::REQ_WRITE: begin
          if (r.access_size == uartrf_pkg::SIZE_BYTE) begin
            case (r.reg_addr)
              uartrf_pkg::ADDR_RBR_THR: begin
                if (dlab) begin
                  divisor_low = r.write_data;
                end else begin
                  o.tx_valid = 1'b1;
                  o.tx_byte  = r.write_data;
                  tx_pending = 1'b1;
                end
              end
              uartrf_pkg::ADDR_IER: begin
                if (dlab) begin
                  divisor_high = r.write_data;
                end else begin
                  int_enable = r.write_data;
                  if ((r.write_data & uartrf_pkg::IER_BAD_BITS) != '0)
                    o.status = uartrf_pkg::ST_IER_UPPER;
                end
              end
              uartrf_pkg::ADDR_IIR_FCR: begin
                if ((r.write_data & ~uartrf_pkg::FCR_OK_BITS) != '0)
                  o.status = uartrf_pkg::ST_FIFO;
              end
              uartrf_pkg::ADDR_LCR: line_control = r.write_data;
              uartrf_pkg::ADDR_MCR: ;
              default:  o.status = uartrf_pkg::ST_UNMAPPED;
            endcase
          end else begin
            o.status = uartrf_pkg::ST_UNMAPPED;
          end
        end
        uartrf_pkg::REQ_RX: begin
          rx_data = r.rx_byte;
          rx_full = 1'b1;
        end
        default: o.status = uartrf_pkg::ST_UNMAPPED;
      endcase
      o.irq = rx_full | tx_pending;
      return o;
    endfunction

    function void note_request(uartrf_pkg::req_t r);
      uartrf_pkg::rsp_t e;
      e = resolve_request(r);
      expected_rsp_q.push_back(e);
      kind_count[r.req_type]++;
      status_count[e.status]++;
      if (e.tx_valid) tx_count++;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] exp);
      if (got !== exp)
        report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, exp));
    endtask

    task check_result(uartrf_pkg::rsp_t got);
      uartrf_pkg::rsp_t e;
      if (expected_rsp_q.size() == 0) begin
        report($sformatf("unexpected result, read_data %0h status %0d",
                         got.read_data, got.status));
        return;
      end
      e = expected_rsp_q.pop_front();
      compare_field("read_data", got.read_data, e.read_data);
      compare_field("tx_valid", {7'd0, got.tx_valid}, {7'd0, e.tx_valid});
      compare_field("tx_byte", got.tx_byte, e.tx_byte);
      compare_field("irq", {7'd0, got.irq}, {7'd0, e.irq});
      compare_field("status", {5'd0, got.status}, {5'd0, e.status});
      checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic no_idle;
  int   ready_hold;
  int   idle_cycles;

  uartrf_req_if req_if ();
  uartrf_rsp_if rsp_if ();

  uart_scoreboard sb;

  uart_register_file_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result stalls: runs of ready high broken by gaps of random length.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold != 0 && !(no_idle && !rsp_if.ready)) begin
      ready_hold <= ready_hold - 1;
    end else if (!rsp_if.ready || no_idle) begin
      rsp_if.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 12);
    end else begin
      ready_hold   <= pick_gap();
      rsp_if.ready <= 1'b0;
    end
  end

  // Monitor and watchdog. Requests are noted before results are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        sb.note_request('{req_type:    req_if.req_type,
                          reg_addr:    req_if.reg_addr,
                          access_size: req_if.access_size,
                          write_data:  req_if.write_data,
                          rx_byte:     req_if.rx_byte});
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result('{read_data: rsp_if.read_data,
                          tx_valid:  rsp_if.tx_valid,
                          tx_byte:   rsp_if.tx_byte,
                          irq:       rsp_if.irq,
                          status:    rsp_if.status});
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a transaction", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_req(uartrf_pkg::req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.req_type;
    req_if.reg_addr    <= r.reg_addr;
    req_if.access_size <= r.access_size;
    req_if.write_data  <= r.write_data;
    req_if.rx_byte     <= r.rx_byte;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic put(uartrf_pkg::req_type_e kind, logic [15:0] addr,
                     uartrf_pkg::access_size_e size,
                     logic [7:0] wdata, logic [7:0] rbyte);
    send_req('{req_type: kind, reg_addr: addr, access_size: size,
               write_data: wdata, rx_byte: rbyte});
  endtask

  function automatic logic [15:0] pick_addr();
    logic [15:0] map [6];
    map = '{uartrf_pkg::ADDR_RBR_THR, uartrf_pkg::ADDR_IER, uartrf_pkg::ADDR_IIR_FCR,
            uartrf_pkg::ADDR_LCR, uartrf_pkg::ADDR_MCR, uartrf_pkg::ADDR_LSR};
    return map[$urandom_range(0, 5)];
  endfunction

  function automatic uartrf_pkg::req_t random_req();
    uartrf_pkg::req_t r;
    int   p;
    r.req_type    = uartrf_pkg::REQ_READ;
    r.reg_addr    = pick_addr();
    r.access_size = ($urandom_range(0, 3) == 0) ? uartrf_pkg::SIZE_WORD
                                                : uartrf_pkg::SIZE_BYTE;
    r.write_data  = 8'($urandom_range(0, 255));
    r.rx_byte     = 8'($urandom_range(0, 255));
    p = $urandom_range(0, 99);
    if (p < 5) begin
      // Noise: any request kind, size and address.
      r.req_type    = 2'($urandom_range(0, 3));
      r.reg_addr    = 16'($urandom_range(0, 65535));
      r.access_size = 2'($urandom_range(0, 3));
    end else if (p < 30) begin
      r.req_type = uartrf_pkg::REQ_RX;
    end else if (p < 62) begin
      r.req_type = uartrf_pkg::REQ_READ;
    end else begin
      r.req_type    = uartrf_pkg::REQ_WRITE;
      r.access_size = uartrf_pkg::SIZE_BYTE;
      // Keep FIFO control writes legal about half of the time.
      if (r.reg_addr == uartrf_pkg::ADDR_IIR_FCR && $urandom_range(0, 1) == 1)
        r.write_data = r.write_data & uartrf_pkg::FCR_OK_BITS;
    end
    return r;
  endfunction

  initial begin
    sb                 = new();
    no_idle            = 1'b0;
    idle_cycles        = 0;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = uartrf_pkg::REQ_READ;
    req_if.reg_addr    = '0;
    req_if.access_size = uartrf_pkg::SIZE_BYTE;
    req_if.write_data  = '0;
    req_if.rx_byte     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty and full receive paths, all IIR answers, DLAB
    // switching, status codes and unmapped accesses.
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_RBR_THR, uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_IIR_FCR, uartrf_pkg::SIZE_BYTE, 8'hFF, 8'hFF);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_LSR,     uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_RX,    uartrf_pkg::ADDR_RBR_THR, uartrf_pkg::SIZE_BYTE, 8'h00, 8'hA5);
    put(uartrf_pkg::REQ_RX,    16'hFFFF,                 uartrf_pkg::SIZE_RSVD, 8'hFF, 8'hFF);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_LSR,     uartrf_pkg::SIZE_WORD, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_IIR_FCR, uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_RBR_THR, uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_RBR_THR, uartrf_pkg::SIZE_BYTE, 8'hFF, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_IIR_FCR, uartrf_pkg::SIZE_WORD, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_IIR_FCR, uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_IER,     uartrf_pkg::SIZE_BYTE, 8'hF0, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_IER,     uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_IIR_FCR, uartrf_pkg::SIZE_BYTE, 8'h06, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_IIR_FCR, uartrf_pkg::SIZE_BYTE, 8'hF9, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_MCR,     uartrf_pkg::SIZE_BYTE, 8'hFF, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_LCR,     uartrf_pkg::SIZE_BYTE, 8'h80, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_RBR_THR, uartrf_pkg::SIZE_BYTE, 8'hFF, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_IER,     uartrf_pkg::SIZE_BYTE, 8'hFF, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_RBR_THR, uartrf_pkg::SIZE_WORD, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_IER,     uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_LCR,     uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_LCR,     uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_RBR_THR, uartrf_pkg::SIZE_HALF, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_WRITE, uartrf_pkg::ADDR_LCR,     uartrf_pkg::SIZE_WORD, 8'h80, 8'h00);
    put(uartrf_pkg::REQ_READ,  16'hFFFF,                 uartrf_pkg::SIZE_RSVD, 8'h00, 8'h00);
    put(uartrf_pkg::REQ_NONE,  uartrf_pkg::ADDR_RBR_THR, uartrf_pkg::SIZE_BYTE, 8'hFF, 8'hFF);
    put(uartrf_pkg::REQ_READ,  uartrf_pkg::ADDR_MCR,     uartrf_pkg::SIZE_BYTE, 8'h00, 8'h00);

    // Random part; every fourth stretch runs back to back on both sides.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) no_idle <= ((i / 150) % 4 == 3);
      send_req(random_req());
    end
    req_if.valid <= 1'b0;

    while (sb.expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.expected_rsp_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_rsp_q.size()));

    $display("Checked %0d results: %0d reads, %0d writes, %0d line bytes, %0d other",
             sb.checked, sb.kind_count[uartrf_pkg::REQ_READ],
             sb.kind_count[uartrf_pkg::REQ_WRITE], sb.kind_count[uartrf_pkg::REQ_RX],
             sb.kind_count[uartrf_pkg::REQ_NONE]);
    $display("Sent %0d tx bytes. Status mix: ok %0d, empty RBR %0d, IER upper %0d, %s",
             sb.tx_count, sb.status_count[uartrf_pkg::ST_OK],
             sb.status_count[uartrf_pkg::ST_EMPTY_RBR],
             sb.status_count[uartrf_pkg::ST_IER_UPPER],
             $sformatf("FIFO %0d, unmapped %0d", sb.status_count[uartrf_pkg::ST_FIFO],
                       sb.status_count[uartrf_pkg::ST_UNMAPPED]));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
